/* rtl/core/flvdmx_pkg.sv */
// Shared types and constants of the FLV tag demultiplexer.
package flvdmx_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] TYPE_AUDIO = 8'd8;
	localparam logic [7:0] TYPE_VIDEO = 8'd9;
	localparam logic [7:0] TYPE_SCRIPT = 8'd18;

	localparam logic [31:0] FILE_HDR_LEN = 32'd9;
	localparam logic [31:0] OFFSET_FIRST = 32'd5;
	localparam logic [31:0] PTS_LEN = 32'd4;
	localparam logic [31:0] TAG_HDR_LEN = 32'd11;
	localparam logic [31:0] TAG_SIZE_LAST = 32'd3;
	localparam logic [31:0] TAG_TIME_LAST = 32'd6;

	typedef enum logic {
		REG_AUDIO_ENABLE = 1'b0,
		REG_VIDEO_ENABLE = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_FILEHDR = 3'd0,
		PH_SKIP = 3'd1,
		PH_PTS = 3'd2,
		PH_TAGHDR = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ROUTE_DROP = 2'd0,
		ROUTE_AUDIO = 2'd1,
		ROUTE_VIDEO = 2'd2
	} route_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_TAG_HDR = 2'd1,
		EV_MEDIA_INFO = 2'd2
	} event_t;

	// one classified byte, front to back
	typedef struct packed {
		logic [7:0] data;
		route_t route;
		event_t ev;
		logic [7:0] kind;
		logic [23:0] size;
		logic [23:0] stamp;
	} item_t;

	// enables from the configuration registers
	typedef struct packed {
		logic audio_en;
		logic video_en;
	} enables_t;

endpackage

/* rtl/core/flvdmx_front.sv */
// Front end: FLV parser state machine, classifies each accepted byte.
module flvdmx_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] in_byte,
	input flvdmx_pkg::enables_t enables,
	output logic push_valid,
	input logic push_ready,
	output flvdmx_pkg::item_t push_item
);

	flvdmx_pkg::phase_t phase_q, phase_n;
	logic [31:0] cnt_q, cnt_n, cnt_inc;
	logic [31:0] offset_q, offset_n;
	logic [7:0] type_q, type_n;
	logic [23:0] size_q, size_n;
	logic [23:0] time_q, time_n;
	logic fire;
	logic [7:0] type_now;
	flvdmx_pkg::route_t route;
	flvdmx_pkg::event_t ev;

	assign in_ready = push_ready;
	assign fire = in_valid & push_ready;
	assign cnt_inc = cnt_q + 32'd1;

	// next state
	always_comb begin
		phase_n = phase_q;
		cnt_n = cnt_inc;
		offset_n = offset_q;
		type_n = type_q;
		size_n = size_q;
		time_n = time_q;
		unique case (phase_q)
			flvdmx_pkg::PH_FILEHDR: begin
				if (cnt_q >= flvdmx_pkg::OFFSET_FIRST)
					offset_n = {offset_q[23:0], in_byte};
				if (cnt_inc >= flvdmx_pkg::FILE_HDR_LEN) begin
					if (offset_n > flvdmx_pkg::FILE_HDR_LEN) begin
						phase_n = flvdmx_pkg::PH_SKIP;
					end else begin
						phase_n = flvdmx_pkg::PH_PTS;
						cnt_n = '0;
					end
				end
			end
			flvdmx_pkg::PH_SKIP: begin
				if (cnt_inc >= offset_q) begin
					phase_n = flvdmx_pkg::PH_PTS;
					cnt_n = '0;
				end
			end
			flvdmx_pkg::PH_PTS: begin
				if (cnt_inc >= flvdmx_pkg::PTS_LEN) begin
					phase_n = flvdmx_pkg::PH_TAGHDR;
					cnt_n = '0;
				end
			end
			flvdmx_pkg::PH_TAGHDR: begin
				if (cnt_q == '0) begin
					type_n = in_byte;
					size_n = '0;
					time_n = '0;
				end else if (cnt_q <= flvdmx_pkg::TAG_SIZE_LAST) begin
					size_n = {size_q[15:0], in_byte};
				end else if (cnt_q <= flvdmx_pkg::TAG_TIME_LAST) begin
					time_n = {time_q[15:0], in_byte};
				end
				if (cnt_inc >= flvdmx_pkg::TAG_HDR_LEN) begin
					cnt_n = '0;
					phase_n = (size_n == '0) ? flvdmx_pkg::PH_PTS : flvdmx_pkg::PH_PAYLOAD;
				end
			end
			flvdmx_pkg::PH_PAYLOAD: begin
				if (cnt_inc >= {8'd0, size_q}) begin
					phase_n = flvdmx_pkg::PH_PTS;
					cnt_n = '0;
				end
			end
			default: begin
				phase_n = flvdmx_pkg::PH_FILEHDR;
				cnt_n = '0;
			end
		endcase
	end

	// classification of the current byte
	always_comb begin
		route = flvdmx_pkg::ROUTE_DROP;
		ev = flvdmx_pkg::EV_NONE;
		type_now = (phase_q == flvdmx_pkg::PH_TAGHDR && cnt_q == '0) ? in_byte : type_q;
		unique case (phase_q)
			flvdmx_pkg::PH_PTS: begin
				if (type_now == flvdmx_pkg::TYPE_VIDEO && enables.video_en)
					route = flvdmx_pkg::ROUTE_VIDEO;
			end
			flvdmx_pkg::PH_TAGHDR: begin
				if (type_now == flvdmx_pkg::TYPE_VIDEO && enables.video_en)
					route = flvdmx_pkg::ROUTE_VIDEO;
				if (cnt_inc >= flvdmx_pkg::TAG_HDR_LEN)
					ev = flvdmx_pkg::EV_TAG_HDR;
			end
			flvdmx_pkg::PH_PAYLOAD: begin
				if (type_now == flvdmx_pkg::TYPE_AUDIO) begin
					if (cnt_q == '0)
						ev = flvdmx_pkg::EV_MEDIA_INFO;
					else if (enables.audio_en)
						route = flvdmx_pkg::ROUTE_AUDIO;
				end else if (type_now == flvdmx_pkg::TYPE_VIDEO) begin
					if (cnt_q == '0)
						ev = flvdmx_pkg::EV_MEDIA_INFO;
					if (enables.video_en)
						route = flvdmx_pkg::ROUTE_VIDEO;
				end
			end
			default: begin
				route = flvdmx_pkg::ROUTE_DROP;
			end
		endcase
	end

	assign push_valid = fire;
	assign push_item = '{data: in_byte, route: route, ev: ev, kind: type_n,
		size: size_n, stamp: time_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= flvdmx_pkg::PH_FILEHDR;
			cnt_q <= '0;
			offset_q <= '0;
			type_q <= '0;
			size_q <= '0;
			time_q <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			cnt_q <= cnt_n;
			offset_q <= offset_n;
			type_q <= type_n;
			size_q <= size_n;
			time_q <= time_n;
		end
	end

endmodule

/* rtl/core/flvdmx_queue.sv */
// Small FIFO between front end and back end.
module flvdmx_queue #(
	parameter int unsigned DEPTH = flvdmx_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input flvdmx_pkg::item_t push_item,
	output logic pop_valid,
	input logic pop_ready,
	output flvdmx_pkg::item_t pop_item
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	flvdmx_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic push, pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid & push_ready;
	assign pop = pop_valid & pop_ready;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/core/flvdmx_back.sv */
// Back end: decodes media info fields and holds the output register.
module flvdmx_back (
	input logic clk,
	input logic arst_n,
	input logic pop_valid,
	output logic pop_ready,
	input flvdmx_pkg::item_t pop_item,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] route,
	output logic [1:0] event_res,
	output logic [7:0] tag_kind,
	output logic [23:0] payload_size,
	output logic [23:0] time_stamp,
	output logic [3:0] audio_format,
	output logic [1:0] audio_rate,
	output logic audio_wide,
	output logic audio_stereo,
	output logic [3:0] video_frame,
	output logic [3:0] video_codec
);

	logic valid_q;
	logic is_info, is_audio, is_video;

	assign pop_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign is_info = (pop_item.ev == flvdmx_pkg::EV_MEDIA_INFO);
	assign is_audio = is_info && pop_item.kind == flvdmx_pkg::TYPE_AUDIO;
	assign is_video = is_info && pop_item.kind == flvdmx_pkg::TYPE_VIDEO;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop_ready)
			valid_q <= pop_valid;
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			out_byte <= pop_item.data;
			route <= pop_item.route;
			event_res <= pop_item.ev;
			tag_kind <= pop_item.kind;
			payload_size <= pop_item.size;
			time_stamp <= pop_item.stamp;
			audio_format <= is_audio ? pop_item.data[7:4] : 4'd0;
			audio_rate <= is_audio ? pop_item.data[3:2] : 2'd0;
			audio_wide <= is_audio ? pop_item.data[1] : 1'b0;
			audio_stereo <= is_audio ? pop_item.data[0] : 1'b0;
			video_frame <= is_video ? pop_item.data[7:4] : 4'd0;
			video_codec <= is_video ? pop_item.data[3:0] : 4'd0;
		end
	end

endmodule

/* rtl/core/flv_tag_demultiplexer.sv */
// FLV tag demultiplexer: front-end parser, queue and output stage.
// Takes one FLV byte per cycle and returns one result per byte with its route
// (dropped, audio payload, video tag bytes), tag header and media info events
// and the current tag's type, size and timestamp. One byte per cycle sustained
// while out_ready stays high; a result passes through a queue entry and the
// output register to reach the outputs; the parser classifies a byte in the
// cycle it is accepted. in_ready falls only when the queue (QUEUE_DEPTH entries)
// is full because out_ready is held low.
// Enable writes take effect from the next byte parsed.
module flv_tag_demultiplexer #(
	parameter int unsigned QUEUE_DEPTH = flvdmx_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] in_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] route,
	output logic [1:0] event_res,
	output logic [7:0] tag_kind,
	output logic [23:0] payload_size,
	output logic [23:0] time_stamp,
	output logic [3:0] audio_format,
	output logic [1:0] audio_rate,
	output logic audio_wide,
	output logic audio_stereo,
	output logic [3:0] video_frame,
	output logic [3:0] video_codec
);

	flvdmx_pkg::enables_t enables_q;
	flvdmx_pkg::item_t push_item, pop_item;
	logic push_valid, push_ready, pop_valid, pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enables_q <= '{audio_en: 1'b1, video_en: 1'b1};
		end else if (cfg_we) begin
			unique case (flvdmx_pkg::reg_index_t'(cfg_index))
				flvdmx_pkg::REG_AUDIO_ENABLE: enables_q.audio_en <= cfg_wdata;
				flvdmx_pkg::REG_VIDEO_ENABLE: enables_q.video_en <= cfg_wdata;
				default: enables_q <= enables_q;
			endcase
		end
	end

	flvdmx_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.enables(enables_q),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item)
	);

	flvdmx_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item)
	);

	flvdmx_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.route(route),
		.event_res(event_res),
		.tag_kind(tag_kind),
		.payload_size(payload_size),
		.time_stamp(time_stamp),
		.audio_format(audio_format),
		.audio_rate(audio_rate),
		.audio_wide(audio_wide),
		.audio_stereo(audio_stereo),
		.video_frame(video_frame),
		.video_codec(video_codec)
	);

	a_audio_route_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && route == flvdmx_pkg::ROUTE_AUDIO) |-> tag_kind == flvdmx_pkg::TYPE_AUDIO)
		else $error("audio route on a non-audio tag");

	a_info_only_on_event: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (audio_format != 4'd0 || video_codec != 4'd0 || video_frame != 4'd0))
		|-> event_res == flvdmx_pkg::EV_MEDIA_INFO)
		else $error("media info fields set without info event");

	a_info_event_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == flvdmx_pkg::EV_MEDIA_INFO)
		|-> (tag_kind == flvdmx_pkg::TYPE_AUDIO || tag_kind == flvdmx_pkg::TYPE_VIDEO))
		else $error("info event on a tag that is neither audio nor video");

endmodule
